// ===== rtl/tbo_pkg.sv =====
// Package for the triangle / box overlap block.
// Holds widths, reset values and register codes shared by the interfaces and the top level.
package tbo_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int HALF_WIDTH      = 23;
    localparam int CFG_IDX_W       = 2;

    localparam logic [HALF_WIDTH-1:0] HALF_RESET = HALF_WIDTH'(4096);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_X = 2'd0,
        REG_HALF_Y = 2'd1,
        REG_HALF_Z = 2'd2
    } t_reg_idx;

endpackage

// ===== rtl/tbo_if.sv =====
// Handshake channels of the triangle / box overlap block: input beat, result beat, config write.
// Depends on tbo_pkg.
interface tbo_in_if import tbo_pkg::*; #(parameter int W = COORD_WIDTH_DEF) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic signed [W-1:0] center_z;
    logic signed [W-1:0] vert0_x;
    logic signed [W-1:0] vert0_y;
    logic signed [W-1:0] vert0_z;
    logic signed [W-1:0] vert1_x;
    logic signed [W-1:0] vert1_y;
    logic signed [W-1:0] vert1_z;
    logic signed [W-1:0] vert2_x;
    logic signed [W-1:0] vert2_y;
    logic signed [W-1:0] vert2_z;

    modport source (output valid, center_x, center_y, center_z, vert0_x, vert0_y, vert0_z,
                    vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, input ready);
    modport sink   (input valid, center_x, center_y, center_z, vert0_x, vert0_y, vert0_z,
                    vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface tbo_out_if ();
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink   (input valid, overlap, output ready);
endinterface

interface tbo_cfg_if import tbo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [HALF_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/triangle_box_overlap.sv =====
// Triangle / axis-aligned box overlap by separating axes, six register stages.
// One beat accepted per cycle while the result side does not stall the pipeline.
// Each stage holds while the stage after it is full and stalled, so bubbles collapse.
// Synchronous active-low reset empties the pipeline and sets each half size to 1.0.
// Depends on tbo_pkg and the channels in tbo_if.
module triangle_box_overlap import tbo_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbo_in_if.sink    i_in,
    tbo_cfg_if.sink   i_cfg,
    tbo_out_if.source o_out
);

    localparam int W   = COORD_WIDTH;
    localparam int HW  = HALF_WIDTH;
    localparam int VW  = W + 1;
    localparam int EW  = W + 1;
    localparam int PRW = EW + VW;
    localparam int RPW = EW + HW;
    localparam int CW0 = 2 * W + 3;
    localparam int CW1 = W + HW + 2;
    localparam int CW  = ((CW0 > CW1) ? CW0 : CW1) + 1;
    localparam int NW  = 2 * EW + 1;
    localparam int AW  = ((W > HW) ? W : HW) + 2;
    localparam int NL  = NW / 2;
    localparam int NH  = NW - NL;
    localparam int MLW = NL + 1 + AW;
    localparam int MHW = NH + AW;
    localparam int PW  = NW + AW;
    localparam int DW  = PW + 2;

    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};
    localparam int PAIR_SEL [3][3][2] = '{
        '{'{0, 2}, '{0, 2}, '{1, 2}},
        '{'{0, 2}, '{0, 2}, '{0, 1}},
        '{'{0, 1}, '{0, 1}, '{1, 2}}
    };

    logic [HW-1:0] r_half [3];
    logic [6:1]    w_en;
    logic [6:1]    r_vld;

    logic signed [W-1:0] w_c   [3];
    logic signed [W-1:0] w_vin [3][3];

    logic signed [VW-1:0] n_s1_v [3][3];
    logic signed [EW-1:0] n_s1_e [3][3];
    logic signed [VW-1:0] r_s1_v [3][3];
    logic signed [EW-1:0] r_s1_e [3][3];

    logic signed [PRW-1:0] n_s2_pa [3][3], n_s2_pb [3][3], n_s2_pc [3][3], n_s2_pd [3][3];
    logic signed [PRW-1:0] r_s2_pa [3][3], r_s2_pb [3][3], r_s2_pc [3][3], r_s2_pd [3][3];
    logic        [RPW-1:0] n_s2_ra [3][3], n_s2_rb [3][3];
    logic        [RPW-1:0] r_s2_ra [3][3], r_s2_rb [3][3];
    logic signed [2*EW-1:0] n_s2_na [3], n_s2_nb [3];
    logic signed [2*EW-1:0] r_s2_na [3], r_s2_nb [3];
    logic                   n_s2_sep, r_s2_sep;
    logic signed [VW-1:0]   r_s2_v0 [3];

    logic signed [CW-1:0] n_s3_p0 [3][3], n_s3_p1 [3][3], n_s3_rad [3][3];
    logic signed [CW-1:0] r_s3_p0 [3][3], r_s3_p1 [3][3], r_s3_rad [3][3];
    logic signed [NW-1:0] n_s3_n [3];
    logic signed [NW-1:0] r_s3_n [3];
    logic                 r_s3_sep;
    logic signed [VW-1:0] r_s3_v0 [3];

    logic                  n_s4_sep, r_s4_sep;
    logic signed [MLW-1:0] n_s4_lmin [3], n_s4_lmax [3], r_s4_lmin [3], r_s4_lmax [3];
    logic signed [MHW-1:0] n_s4_hmin [3], n_s4_hmax [3], r_s4_hmin [3], r_s4_hmax [3];

    logic signed [PW-1:0] n_s5_min [3], n_s5_max [3], r_s5_min [3], r_s5_max [3];
    logic                 r_s5_sep;

    logic                 n_s6_ovl, r_s6_ovl;

    // Config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half[0] <= HALF_RESET;
            r_half[1] <= HALF_RESET;
            r_half[2] <= HALF_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HALF_X: r_half[0] <= i_cfg.data;
                REG_HALF_Y: r_half[1] <= i_cfg.data;
                REG_HALF_Z: r_half[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage enables: advance when empty or when the next stage advances
    assign w_en[6] = !r_vld[6] || o_out.ready;
    assign w_en[5] = !r_vld[5] || w_en[6];
    assign w_en[4] = !r_vld[4] || w_en[5];
    assign w_en[3] = !r_vld[3] || w_en[4];
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];

    assign i_in.ready = w_en[1];
    assign o_out.valid   = r_vld[6];
    assign o_out.overlap = r_s6_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) r_vld[1] <= i_in.valid;
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
            if (w_en[4]) r_vld[4] <= r_vld[3];
            if (w_en[5]) r_vld[5] <= r_vld[4];
            if (w_en[6]) r_vld[6] <= r_vld[5];
        end
    end

    // Stage 1: relative vertices and edges
    assign w_c[0] = i_in.center_x;
    assign w_c[1] = i_in.center_y;
    assign w_c[2] = i_in.center_z;
    assign w_vin[0][0] = i_in.vert0_x;
    assign w_vin[0][1] = i_in.vert0_y;
    assign w_vin[0][2] = i_in.vert0_z;
    assign w_vin[1][0] = i_in.vert1_x;
    assign w_vin[1][1] = i_in.vert1_y;
    assign w_vin[1][2] = i_in.vert1_z;
    assign w_vin[2][0] = i_in.vert2_x;
    assign w_vin[2][1] = i_in.vert2_y;
    assign w_vin[2][2] = i_in.vert2_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s1_v[i][j] = VW'(w_vin[i][j]) - VW'(w_c[j]);
                n_s1_e[i][j] = EW'(w_vin[NXT1[i]][j]) - EW'(w_vin[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_v <= n_s1_v;
            r_s1_e <= n_s1_e;
        end
    end

    // Stage 2: cross-axis products, radius products, normal products, extent test
    always_comb begin
        logic [EW-1:0]       abs_u, abs_w;
        logic signed [AW-1:0] hp, vx0, vx1, vx2;
        logic                 sep;
        sep = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                abs_w = r_s1_e[k][NXT2[t]][EW-1] ? EW'(-r_s1_e[k][NXT2[t]])
                                                 : EW'(r_s1_e[k][NXT2[t]]);
                abs_u = r_s1_e[k][NXT1[t]][EW-1] ? EW'(-r_s1_e[k][NXT1[t]])
                                                 : EW'(r_s1_e[k][NXT1[t]]);
                n_s2_pa[k][t] = r_s1_e[k][NXT2[t]] * r_s1_v[PAIR_SEL[k][t][0]][NXT1[t]];
                n_s2_pb[k][t] = r_s1_e[k][NXT1[t]] * r_s1_v[PAIR_SEL[k][t][0]][NXT2[t]];
                n_s2_pc[k][t] = r_s1_e[k][NXT2[t]] * r_s1_v[PAIR_SEL[k][t][1]][NXT1[t]];
                n_s2_pd[k][t] = r_s1_e[k][NXT1[t]] * r_s1_v[PAIR_SEL[k][t][1]][NXT2[t]];
                n_s2_ra[k][t] = RPW'(abs_w) * RPW'(r_half[NXT1[t]]);
                n_s2_rb[k][t] = RPW'(abs_u) * RPW'(r_half[NXT2[t]]);
            end
        end
        for (int j = 0; j < 3; j++) begin
            n_s2_na[j] = r_s1_e[0][NXT1[j]] * r_s1_e[1][NXT2[j]];
            n_s2_nb[j] = r_s1_e[0][NXT2[j]] * r_s1_e[1][NXT1[j]];
            hp  = $signed(AW'(r_half[j]));
            vx0 = AW'(r_s1_v[0][j]);
            vx1 = AW'(r_s1_v[1][j]);
            vx2 = AW'(r_s1_v[2][j]);
            if ((vx0 > hp && vx1 > hp && vx2 > hp) || (vx0 < -hp && vx1 < -hp && vx2 < -hp))
                sep = 1'b1;
        end
        n_s2_sep = sep;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_pa  <= n_s2_pa;
            r_s2_pb  <= n_s2_pb;
            r_s2_pc  <= n_s2_pc;
            r_s2_pd  <= n_s2_pd;
            r_s2_ra  <= n_s2_ra;
            r_s2_rb  <= n_s2_rb;
            r_s2_na  <= n_s2_na;
            r_s2_nb  <= n_s2_nb;
            r_s2_sep <= n_s2_sep;
            for (int j = 0; j < 3; j++) r_s2_v0[j] <= r_s1_v[0][j];
        end
    end

    // Stage 3: projections, radii, normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                n_s3_p0[k][t]  = CW'(r_s2_pa[k][t]) - CW'(r_s2_pb[k][t]);
                n_s3_p1[k][t]  = CW'(r_s2_pc[k][t]) - CW'(r_s2_pd[k][t]);
                n_s3_rad[k][t] = $signed(CW'(r_s2_ra[k][t])) + $signed(CW'(r_s2_rb[k][t]));
            end
        end
        for (int j = 0; j < 3; j++)
            n_s3_n[j] = NW'(r_s2_na[j]) - NW'(r_s2_nb[j]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_p0  <= n_s3_p0;
            r_s3_p1  <= n_s3_p1;
            r_s3_rad <= n_s3_rad;
            r_s3_n   <= n_s3_n;
            r_s3_sep <= r_s2_sep;
            r_s3_v0  <= r_s2_v0;
        end
    end

    // Stage 4: edge-axis compares, split plane products
    always_comb begin
        logic                 sep, pos;
        logic signed [AW-1:0] hp, ve, a, b, smin, smax;
        logic signed [NH-1:0] nhi;
        logic signed [NL:0]   nlo;
        sep = r_s3_sep;
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                if ((r_s3_p0[k][t] > r_s3_rad[k][t] && r_s3_p1[k][t] > r_s3_rad[k][t]) ||
                    (r_s3_p0[k][t] < -r_s3_rad[k][t] && r_s3_p1[k][t] < -r_s3_rad[k][t]))
                    sep = 1'b1;
            end
        end
        n_s4_sep = sep;
        for (int j = 0; j < 3; j++) begin
            hp   = $signed(AW'(r_half[j]));
            ve   = AW'(r_s3_v0[j]);
            a    = -hp - ve;
            b    = hp - ve;
            pos  = !r_s3_n[j][NW-1] && (r_s3_n[j] != '0);
            smin = pos ? a : b;
            smax = pos ? b : a;
            nhi  = r_s3_n[j][NW-1:NL];
            nlo  = $signed({1'b0, r_s3_n[j][NL-1:0]});
            n_s4_lmin[j] = nlo * smin;
            n_s4_lmax[j] = nlo * smax;
            n_s4_hmin[j] = nhi * smin;
            n_s4_hmax[j] = nhi * smax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_sep  <= n_s4_sep;
            r_s4_lmin <= n_s4_lmin;
            r_s4_lmax <= n_s4_lmax;
            r_s4_hmin <= n_s4_hmin;
            r_s4_hmax <= n_s4_hmax;
        end
    end

    // Stage 5: merge partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_s5_min[j] = (PW'(r_s4_hmin[j]) <<< NL) + PW'(r_s4_lmin[j]);
            n_s5_max[j] = (PW'(r_s4_hmax[j]) <<< NL) + PW'(r_s4_lmax[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_min <= n_s5_min;
            r_s5_max <= n_s5_max;
            r_s5_sep <= r_s4_sep;
        end
    end

    // Stage 6: plane test and result
    always_comb begin
        logic signed [DW-1:0] dmin, dmax;
        dmin = DW'(r_s5_min[0]) + DW'(r_s5_min[1]) + DW'(r_s5_min[2]);
        dmax = DW'(r_s5_max[0]) + DW'(r_s5_max[1]) + DW'(r_s5_max[2]);
        n_s6_ovl = !r_s5_sep && !(dmin > 0) && !dmax[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) r_s6_ovl <= n_s6_ovl;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for triangle_box_overlap: random and directed triangle/box beats,
// checked against an internal separating-axis predictor. Depends on tbo_pkg and tbo_if.
module tb;
    import tbo_pkg::*;

    typedef logic signed [127:0] t_wide;
    typedef bit [11:0][23:0]     t_tri;

    localparam t_cfg_idx REG_SPARE = t_cfg_idx'(3);
    localparam logic [HALF_WIDTH-1:0] HALF_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    tbo_in_if #(.W(24)) in_if();
    tbo_out_if          out_if();
    tbo_cfg_if          cfg_if();

    triangle_box_overlap #(.COORD_WIDTH(24)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    logic [HALF_WIDTH-1:0] half_sz[3];
    t_tri pending_tris[$];
    bit   expected_hits[$];
    int   errors;
    int   send_gap;
    int   recv_stall;
    bit   bursty;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit tri_box_hit(t_tri f);
        t_wide c[3], v[3][3], e[3][3], h[3], n[3];
        t_wide p0, p1, rad, lo, hi, dmin, dmax, a, b;
        int u, w, s0, s1;
        for (int j = 0; j < 3; j++) begin
            h[j] = t_wide'({1'b0, half_sz[j]});
            c[j] = t_wide'($signed(f[j]));
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                v[i][j] = t_wide'($signed(f[3 + 3 * i + j])) - c[j];
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                e[k][j] = v[(k + 1) % 3][j] - v[k][j];
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                u  = (t + 1) % 3;
                w  = (t + 2) % 3;
                s0 = (t == 2 && k != 1) ? 1 : 0;
                s1 = ((k == 1 && t == 2) || (k == 2 && t < 2)) ? 1 : 2;
                p0 = e[k][w] * v[s0][u] - e[k][u] * v[s0][w];
                p1 = e[k][w] * v[s1][u] - e[k][u] * v[s1][w];
                rad = (e[k][w] < 0 ? -e[k][w] : e[k][w]) * h[u]
                    + (e[k][u] < 0 ? -e[k][u] : e[k][u]) * h[w];
                lo = (p0 < p1) ? p0 : p1;
                hi = (p0 < p1) ? p1 : p0;
                if (lo > rad || hi < -rad)
                    return 1'b0;
            end
        end
        for (int j = 0; j < 3; j++) begin
            lo = v[0][j];
            hi = v[0][j];
            for (int i = 1; i < 3; i++) begin
                if (v[i][j] < lo) lo = v[i][j];
                if (v[i][j] > hi) hi = v[i][j];
            end
            if (lo > h[j] || hi < -h[j])
                return 1'b0;
        end
        for (int j = 0; j < 3; j++) begin
            u = (j + 1) % 3;
            w = (j + 2) % 3;
            n[j] = e[0][u] * e[1][w] - e[0][w] * e[1][u];
        end
        dmin = 0;
        dmax = 0;
        for (int j = 0; j < 3; j++) begin
            a = -h[j] - v[0][j];
            b = h[j] - v[0][j];
            if (n[j] > 0) begin
                dmin = dmin + n[j] * a;
                dmax = dmax + n[j] * b;
            end else begin
                dmin = dmin + n[j] * b;
                dmax = dmax + n[j] * a;
            end
        end
        return !(dmin > 0) && !(dmax < 0);
    endfunction

    task automatic report(string what, bit got, bit want);
        $display("tb: mismatch %s: overlap %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver: one beat per item, random gap after each unless bursty
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid)
                expected_hits.push_back(tri_box_hit({in_if.vert2_z, in_if.vert2_y,
                    in_if.vert2_x, in_if.vert1_z, in_if.vert1_y, in_if.vert1_x,
                    in_if.vert0_z, in_if.vert0_y, in_if.vert0_x,
                    in_if.center_z, in_if.center_y, in_if.center_x}));
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pending_tris.size() > 0) begin
                t_tri f;
                f = pending_tris.pop_front();
                {in_if.vert2_z, in_if.vert2_y, in_if.vert2_x, in_if.vert1_z, in_if.vert1_y,
                 in_if.vert1_x, in_if.vert0_z, in_if.vert0_y, in_if.vert0_x,
                 in_if.center_z, in_if.center_y, in_if.center_x} <= f;
                in_if.valid <= 1'b1;
                send_gap    <= bursty ? 0 : $urandom_range(0, 17);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor: random stalls on the result side, checks each result beat against the expected queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall   <= 0;
        end else if (out_if.valid && out_if.ready) begin
            int s;
            if (expected_hits.size() == 0)
                report("unexpected beat", out_if.overlap, 1'b0);
            else if (out_if.overlap !== expected_hits[0])
                report("overlap", out_if.overlap, expected_hits.pop_front());
            else
                void'(expected_hits.pop_front());
            s = bursty ? 0 : $urandom_range(0, 17);
            recv_stall   <= s;
            out_if.ready <= (s == 0);
        end else if (recv_stall > 0) begin
            recv_stall   <= recv_stall - 1;
            out_if.ready <= (recv_stall == 1);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic write_half(t_cfg_idx idx, logic [HALF_WIDTH-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_HALF_X: half_sz[0] = val;
            REG_HALF_Y: half_sz[1] = val;
            REG_HALF_Z: half_sz[2] = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_tris.size() > 0 || in_if.valid || expected_hits.size() > 0);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic t_tri rand_tri();
        t_tri f;
        int   sc;
        for (int j = 0; j < 12; j++) f[j] = 24'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            sc = 1 << $urandom_range(10, 17);
            for (int j = 3; j < 12; j++)
                f[j] = f[j % 3] + 24'($signed($urandom_range(0, 2 * sc)) - sc);
        end
        return f;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) bursty = ($urandom_range(0, 3) == 0);
            pending_tris.push_back(rand_tri());
        end
        drain();
    endtask

    function automatic t_tri tri_of(int cx, int cy, int cz, int ax, int ay, int az,
                                    int bx, int by, int bz, int dx, int dy, int dz);
        return {24'(dz), 24'(dy), 24'(dx), 24'(bz), 24'(by), 24'(bx),
                24'(az), 24'(ay), 24'(ax), 24'(cz), 24'(cy), 24'(cx)};
    endfunction

    initial begin
        errors       = 0;
        bursty       = 1'b0;
        half_sz      = '{HALF_RESET, HALF_RESET, HALF_RESET};
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_HALF_X;
        cfg_if.data  = '0;
        in_if.valid  = 1'b0;
        {in_if.center_x, in_if.center_y, in_if.center_z, in_if.vert0_x, in_if.vert0_y,
         in_if.vert0_z, in_if.vert1_x, in_if.vert1_y, in_if.vert1_z, in_if.vert2_x,
         in_if.vert2_y, in_if.vert2_z} = '0;
        out_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_tris.push_back('0);
        pending_tris.push_back({12{24'h7fffff}});
        pending_tris.push_back({12{24'h800000}});
        pending_tris.push_back({{9{24'h7fffff}}, {3{24'h800000}}});
        pending_tris.push_back({{9{24'h800000}}, {3{24'h7fffff}}});
        pending_tris.push_back(tri_of(0, 0, 0, 4096, 0, 0, 4096, 4096, 0, 4096, 0, 4096));
        pending_tris.push_back(tri_of(0, 0, 0, 4097, 0, 0, 4097, 4096, 0, 4097, 0, 4096));
        pending_tris.push_back(tri_of(0, 0, 0, -4097, 0, 0, -4097, 9, 0, -4097, 0, 9));
        pending_tris.push_back(tri_of(0, 0, 0, 0, 0, 0, 100, 100, 100, 200, 200, 200));
        pending_tris.push_back(tri_of(0, 0, 0, 8192, 0, 0, 0, 8192, 0, 0, 0, 8192));
        pending_tris.push_back(tri_of(0, 0, 0, 12288, 0, 0, 0, 12288, 0, 0, 0, 12288));
        pending_tris.push_back(tri_of(0, 0, 0, 12289, 0, 0, 0, 12289, 0, 0, 0, 12289));
        pending_tris.push_back(tri_of(0, 0, 0, 8193, 0, 0, 0, 8193, 0, 0, 0, 8192));
        pending_tris.push_back(tri_of(0, 0, 0, 5000, 5000, -9000, 5000, -9000, 5000,
                                      -9000, 5000, 5000));
        pending_tris.push_back(tri_of(0, 0, 0, 6000, 9000, 0, 9000, 6000, 0, 9000, 9000, 0));
        pending_tris.push_back(tri_of(4096, -4096, 8192, 4096, -4096, 8192, 4096, -4096,
                                      8192, 4096, -4096, 8192));
        pending_tris.push_back(tri_of(0, 0, 0, 8192, 8192, 0, 8192, 8192, 0, 0, 8193, 0));
        pending_tris.push_back(tri_of(-8388608, 0, 0, 8388607, 0, 0, 8388607, 1, 0,
                                      8388607, 0, 1));
        pending_tris.push_back(tri_of(0, 0, 0, -20000, -20000, 0, 20000, -20000, 0,
                                      0, 20000, 0));
        pending_tris.push_back(tri_of(0, 0, 0, -20000, -20000, 4097, 20000, -20000, 4097,
                                      0, 20000, 4097));
        drain();
        run_random(80);

        write_half(REG_HALF_X, '0);
        write_half(REG_HALF_Y, '0);
        write_half(REG_HALF_Z, '0);
        pending_tris.push_back('0);
        pending_tris.push_back(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        run_random(60);

        write_half(REG_HALF_X, HALF_MAX);
        write_half(REG_HALF_Y, HALF_MAX);
        write_half(REG_HALF_Z, HALF_MAX);
        pending_tris.push_back({{9{24'h7fffff}}, {3{24'h800000}}});
        run_random(60);

        write_half(REG_HALF_X, 23'($urandom));
        write_half(REG_HALF_Y, 23'($urandom_range(0, 1 << 17)));
        write_half(REG_HALF_Z, 23'($urandom_range(0, 1 << 14)));
        write_half(REG_SPARE, '0);
        run_random(100);

        write_half(REG_HALF_X, 23'd1);
        write_half(REG_HALF_Y, 23'($urandom_range(1 << 12, 1 << 16)));
        write_half(REG_HALF_Z, HALF_MAX);
        run_random(100);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: done, errors");
        $finish;
    end
endmodule
